/* src/assert_macros.svh */
// Assertion macros used by the checker module.
// Depends on nothing; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked, switched off while reset is low.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion, clocked, also checked through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pcse_pkg.sv */
// Shared types, widths, command codes and the 48-bit saturation helper
// for the spline evaluator. No dependencies.
package pcse_pkg;

    localparam int DATA_W  = 48;   // Q24.24 words
    localparam int U_W     = 32;   // Q4.28 parameter and breakpoints
    localparam int BP_W    = 32;
    localparam int CNT_W   = 5;    // point count
    localparam int IDX_W   = 6;
    localparam int CMD_W   = 3;
    localparam int SEG_W   = 4;
    localparam int SUM_W   = 54;   // signed headroom before clipping
    localparam int HALF_W  = 24;   // multiplicand split
    localparam int PROD_W  = HALF_W + U_W;
    localparam int WIDE_W  = PROD_W + HALF_W;
    localparam int FRAC_W  = 28;
    localparam int MAG_W   = WIDE_W - FRAC_W;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 200;
    localparam int M_TUSER_W = 2;

    localparam logic [CMD_W-1:0] CMD_EVAL   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_BP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_CX  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WR_CY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WR_EPX = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WR_EPY = 3'd5;

    typedef struct packed {
        logic              bp_we;
        logic              cx_we;
        logic              cy_we;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic                     done;
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } qmac_res_t;

    typedef struct packed {
        logic                     clipped;
        logic signed [DATA_W-1:0] value;
    } sat_t;

    // clip a wide signed value to the 48-bit range
    function automatic sat_t sat48(input logic signed [SUM_W-1:0] v);
        sat_t                    r;
        logic [SUM_W-DATA_W:0]   hi;
        hi = v[SUM_W-1:DATA_W-1];
        if ((&hi) || !(|hi)) begin
            r.clipped = 1'b0;
            r.value   = v[DATA_W-1:0];
        end else begin
            r.clipped = 1'b1;
            r.value   = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

/* src/pcse_table.sv */
// Breakpoint memory and paired x/y coefficient memory, registered read ports.
// Depends on pcse_pkg.
module pcse_table #(
    parameter int  MAX_SEGMENTS = 16,
    localparam int NBP   = MAX_SEGMENTS + 1,
    localparam int NCO   = 4 * MAX_SEGMENTS,
    localparam int BP_AW = $clog2(NBP),
    localparam int CF_AW = $clog2(NCO)
) (
    input  logic                          aclk,
    input  pcse_pkg::tbl_wr_t             wr,
    input  logic [BP_AW-1:0]              bp_raddr,
    input  logic [CF_AW-1:0]              cf_raddr,
    output logic [pcse_pkg::BP_W-1:0]     bp_rdata,
    output logic [2*pcse_pkg::DATA_W-1:0] cf_rdata   // {y, x}
);

    logic [pcse_pkg::BP_W-1:0]     bp_mem [NBP];
    logic [2*pcse_pkg::DATA_W-1:0] cf_mem [NCO];

    logic bp_in_range;
    logic cf_in_range;

    assign bp_in_range = (32'(wr.addr) < 32'(NBP));
    assign cf_in_range = (32'(wr.addr) < 32'(NCO));

    always_ff @(posedge aclk) begin
        if (wr.bp_we && bp_in_range) begin
            bp_mem[BP_AW'(wr.addr)] <= wr.data[pcse_pkg::BP_W-1:0];
        end
        if (wr.cx_we && cf_in_range) begin
            cf_mem[CF_AW'(wr.addr)][pcse_pkg::DATA_W-1:0] <= wr.data;
        end
        if (wr.cy_we && cf_in_range) begin
            cf_mem[CF_AW'(wr.addr)][2*pcse_pkg::DATA_W-1:pcse_pkg::DATA_W] <= wr.data;
        end
        bp_rdata <= bp_mem[bp_raddr];
        cf_rdata <= cf_mem[cf_raddr];
    end

endmodule

/* src/pcse_qmac.sv */
// Multiply-add unit: sat48(round(a*u >> 28) + c), one 24x32 multiplier
// used twice per product, with a registered result. Depends on pcse_pkg.
module pcse_qmac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [pcse_pkg::DATA_W-1:0]  a,
    input  logic signed [pcse_pkg::U_W-1:0]     b,
    input  logic signed [pcse_pkg::DATA_W-1:0]  c,
    output pcse_pkg::qmac_res_t                 res
);

    localparam logic [pcse_pkg::WIDE_W-1:0] RND = pcse_pkg::WIDE_W'(1) << (pcse_pkg::FRAC_W - 1);

    logic [3:0]                          v_reg;
    logic                                done_reg;
    logic [pcse_pkg::DATA_W-1:0]         ma_reg;
    logic [pcse_pkg::U_W-1:0]            mb_reg;
    logic                                neg_reg;
    logic signed [pcse_pkg::DATA_W-1:0]  c_reg;
    logic [pcse_pkg::PROD_W-1:0]         plo_reg;
    logic [pcse_pkg::PROD_W-1:0]         phi_reg;
    logic [pcse_pkg::MAG_W-1:0]          m_reg;
    logic                                sat_reg;
    logic signed [pcse_pkg::DATA_W-1:0]  val_reg;

    logic [pcse_pkg::HALF_W-1:0]         mul_op;
    logic [pcse_pkg::PROD_W-1:0]         prod;
    logic [pcse_pkg::WIDE_W-1:0]         wide_sum;
    logic signed [pcse_pkg::SUM_W-1:0]   mag_s;
    logic signed [pcse_pkg::SUM_W-1:0]   total;
    pcse_pkg::sat_t                      clip;

    // low half first, then high half
    assign mul_op   = v_reg[0] ? ma_reg[pcse_pkg::HALF_W-1:0]
                               : ma_reg[pcse_pkg::DATA_W-1:pcse_pkg::HALF_W];
    assign prod     = pcse_pkg::PROD_W'(mul_op) * pcse_pkg::PROD_W'(mb_reg);
    assign wide_sum = {phi_reg, {pcse_pkg::HALF_W{1'b0}}}
                    + {{pcse_pkg::HALF_W{1'b0}}, plo_reg} + RND;

    always_comb begin
        mag_s = pcse_pkg::SUM_W'(m_reg);
        total = (neg_reg ? -mag_s : mag_s) + pcse_pkg::SUM_W'(c_reg);
        clip  = pcse_pkg::sat48(total);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end else begin
            v_reg    <= {v_reg[2:0], start};
            done_reg <= v_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg  <= a[pcse_pkg::DATA_W-1] ? -a : a;
            mb_reg  <= b[pcse_pkg::U_W-1] ? -b : b;
            neg_reg <= a[pcse_pkg::DATA_W-1] ^ b[pcse_pkg::U_W-1];
            c_reg   <= c;
        end
        if (v_reg[0]) plo_reg <= prod;
        if (v_reg[1]) phi_reg <= prod;
        if (v_reg[2]) m_reg   <= wide_sum[pcse_pkg::WIDE_W-1:pcse_pkg::FRAC_W];
        if (v_reg[3]) begin
            sat_reg <= clip.clipped;
            val_reg <= clip.value;
        end
    end

    assign res.done  = done_reg;
    assign res.sat   = sat_reg;
    assign res.value = val_reg;

endmodule

/* src/piecewise_cubic_spline_evaluator.sv */
// Piecewise cubic spline evaluator, top level: command decode, sequencer,
// output register. Depends on pcse_pkg, pcse_table and pcse_qmac.
//
// Loads one table word per transfer (breakpoints, x/y cubic coefficients,
// last control point) and, on an evaluate command, returns x(u), y(u),
// dx/du and dy/du of the first segment whose upper breakpoint is at or above
// u, Q24.24 with clipping. Load transfers give no result and leave the
// block ready. An evaluate with fewer than two points answers all zeros.
// Otherwise the breakpoints are scanned one per cycle from the breakpoint
// memory; an evaluate runs through the scan, the fetch of the four
// coefficient pairs, and three multiply-add passes (two for the slopes)
// through the four multiply units, each of which splits a 48x32 product
// over one 24x32 multiplier. A finished result waits in the output
// register while the next transfer is taken in.
module piecewise_cubic_spline_evaluator #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: point_count
    input  logic                               cfg_we,
    input  logic [pcse_pkg::CNT_W-1:0]         cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [5:0] table_index, [53:6] load_value, [85:54] param_u, [87:86] zero
    input  logic [pcse_pkg::S_TDATA_W-1:0]     s_tdata,
    // [2:0] cmd
    input  logic [pcse_pkg::CMD_W-1:0]         s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [47:0] point_x, [95:48] point_y, [143:96] slope_x,
    // [191:144] slope_y, [195:192] segment, [199:196] zero
    output logic [pcse_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] beyond_end, [1] saturated
    output logic [pcse_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int NBP   = MAX_SEGMENTS + 1;
    localparam int NCO   = 4 * MAX_SEGMENTS;
    localparam int BP_AW = $clog2(NBP);
    localparam int CF_AW = $clog2(NCO);

    localparam int DW    = pcse_pkg::DATA_W;
    localparam int CW    = pcse_pkg::CNT_W;
    localparam int VAL_LSB = pcse_pkg::IDX_W;
    localparam int U_LSB   = VAL_LSB + DW;
    localparam int PAD_W   = pcse_pkg::M_TDATA_W - 4 * DW - pcse_pkg::SEG_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_FETCH  = 6'b000100,
        S_PREP   = 6'b001000,
        S_CALC   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // ---- input decode ----
    logic [pcse_pkg::CMD_W-1:0]    s_cmd;
    logic [pcse_pkg::IDX_W-1:0]    s_idx;
    logic signed [DW-1:0]          s_val;
    logic signed [pcse_pkg::U_W-1:0] s_u;
    logic                          accept;

    assign s_cmd  = s_tuser;
    assign s_idx  = s_tdata[pcse_pkg::IDX_W-1:0];
    assign s_val  = s_tdata[U_LSB-1:VAL_LSB];
    assign s_u    = s_tdata[U_LSB+pcse_pkg::U_W-1:U_LSB];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // ---- configuration and held state ----
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_eff;
    logic [CW-1:0]        cnt_last;   // index of last segment
    logic                 few_points;
    logic signed [DW-1:0] epx_reg, epy_reg;

    assign cnt_eff    = (32'(cnt_reg) > 32'(NBP)) ? CW'(NBP) : cnt_reg;
    assign few_points = (cnt_eff < CW'(2));
    assign cnt_last   = cnt_eff - CW'(2);

    // ---- tables ----
    pcse_pkg::tbl_wr_t         tbl_wr;
    logic [BP_AW-1:0]          bp_raddr;
    logic [CF_AW-1:0]          cf_raddr;
    logic [pcse_pkg::BP_W-1:0] bp_rdata;
    logic [2*DW-1:0]           cf_rdata;

    assign tbl_wr.bp_we = accept && (s_cmd == pcse_pkg::CMD_WR_BP);
    assign tbl_wr.cx_we = accept && (s_cmd == pcse_pkg::CMD_WR_CX);
    assign tbl_wr.cy_we = accept && (s_cmd == pcse_pkg::CMD_WR_CY);
    assign tbl_wr.addr  = s_idx;
    assign tbl_wr.data  = s_val;

    pcse_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_table (
        .aclk     (aclk),
        .wr       (tbl_wr),
        .bp_raddr (bp_raddr),
        .cf_raddr (cf_raddr),
        .bp_rdata (bp_rdata),
        .cf_rdata (cf_rdata)
    );

    // ---- working registers ----
    logic signed [pcse_pkg::U_W-1:0] u_reg;
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        seg_reg;
    logic                 beyond_reg;
    logic                 zero_reg;
    logic                 sat_reg;
    logic [2:0]           k_reg;      // coefficient fetch slot
    logic [1:0]           step_reg;   // Horner pass
    logic                 start_reg, start_next;
    logic signed [DW-1:0] cx_reg [4];
    logic signed [DW-1:0] cy_reg [4];
    logic signed [DW-1:0] t3x_reg, t2x_reg, t3y_reg, t2y_reg;
    logic signed [DW-1:0] accpx_reg, accpy_reg, accsx_reg, accsy_reg;

    // ---- breakpoint scan ----
    logic hit, search_done;

    assign hit         = ($signed(u_reg) <= $signed(bp_rdata));
    assign search_done = hit || (i_reg == cnt_last);

    always_comb begin
        if ((state_reg == S_SEARCH) && !search_done) begin
            bp_raddr = BP_AW'(i_reg + CW'(2));
        end else begin
            bp_raddr = BP_AW'(1);
        end
    end

    assign cf_raddr = CF_AW'({seg_reg, k_reg[1:0]});

    // ---- slope pre-scaling: 3*c3 and 2*c2 ----
    logic signed [pcse_pkg::SUM_W-1:0] wx3, wx2, wy3, wy2;
    pcse_pkg::sat_t t3x, t2x, t3y, t2y;

    always_comb begin
        wx3 = pcse_pkg::SUM_W'(cx_reg[0]);
        wx2 = pcse_pkg::SUM_W'(cx_reg[1]);
        wy3 = pcse_pkg::SUM_W'(cy_reg[0]);
        wy2 = pcse_pkg::SUM_W'(cy_reg[1]);
        t3x = pcse_pkg::sat48(wx3 + (wx3 <<< 1));
        t2x = pcse_pkg::sat48(wx2 <<< 1);
        t3y = pcse_pkg::sat48(wy3 + (wy3 <<< 1));
        t2y = pcse_pkg::sat48(wy2 <<< 1);
    end

    // ---- multiply-add lanes ----
    logic signed [DW-1:0] px_a, px_c, py_a, py_c, sx_a, sx_c, sy_a, sy_c;
    logic                 pt_start, sl_start;
    pcse_pkg::qmac_res_t  px_res, py_res, sx_res, sy_res;

    always_comb begin
        px_a = (step_reg == 2'd0) ? cx_reg[0] : accpx_reg;
        py_a = (step_reg == 2'd0) ? cy_reg[0] : accpy_reg;
        case (step_reg)
            2'd0:    begin px_c = cx_reg[1]; py_c = cy_reg[1]; end
            2'd1:    begin px_c = cx_reg[2]; py_c = cy_reg[2]; end
            default: begin px_c = cx_reg[3]; py_c = cy_reg[3]; end
        endcase
        sx_a = (step_reg == 2'd0) ? t3x_reg : accsx_reg;
        sx_c = (step_reg == 2'd0) ? t2x_reg : cx_reg[2];
        sy_a = (step_reg == 2'd0) ? t3y_reg : accsy_reg;
        sy_c = (step_reg == 2'd0) ? t2y_reg : cy_reg[2];
    end

    // slope chains need two passes only
    assign pt_start = start_reg;
    assign sl_start = start_reg && (step_reg != 2'd2);

    pcse_qmac u_qmac_px (
        .aclk(aclk), .aresetn(aresetn), .start(pt_start),
        .a(px_a), .b(u_reg), .c(px_c), .res(px_res)
    );
    pcse_qmac u_qmac_py (
        .aclk(aclk), .aresetn(aresetn), .start(pt_start),
        .a(py_a), .b(u_reg), .c(py_c), .res(py_res)
    );
    pcse_qmac u_qmac_sx (
        .aclk(aclk), .aresetn(aresetn), .start(sl_start),
        .a(sx_a), .b(u_reg), .c(sx_c), .res(sx_res)
    );
    pcse_qmac u_qmac_sy (
        .aclk(aclk), .aresetn(aresetn), .start(sl_start),
        .a(sy_a), .b(u_reg), .c(sy_c), .res(sy_res)
    );

    // ---- output register ----
    logic                              m_tvalid_reg;
    logic [pcse_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic [pcse_pkg::M_TUSER_W-1:0]    m_tuser_reg;
    logic                              out_free, out_load;
    logic signed [DW-1:0]              res_px, res_py, res_sx, res_sy;
    logic [pcse_pkg::SEG_W-1:0]        res_seg;
    logic                              res_beyond, res_sat;

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_DONE) && out_free;

    always_comb begin
        if (zero_reg) begin
            res_px     = '0;
            res_py     = '0;
            res_sx     = '0;
            res_sy     = '0;
            res_seg    = '0;
            res_beyond = 1'b0;
            res_sat    = 1'b0;
        end else begin
            // past the end the point is the stored last control point
            res_px     = beyond_reg ? epx_reg : accpx_reg;
            res_py     = beyond_reg ? epy_reg : accpy_reg;
            res_sx     = accsx_reg;
            res_sy     = accsy_reg;
            res_seg    = seg_reg[pcse_pkg::SEG_W-1:0];
            res_beyond = beyond_reg;
            res_sat    = sat_reg;
        end
    end

    // ---- sequencer ----
    always_comb begin
        state_next = state_reg;
        start_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept && (s_cmd == pcse_pkg::CMD_EVAL)) begin
                    state_next = few_points ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (search_done) state_next = S_FETCH;
            end
            S_FETCH: begin
                if (k_reg == 3'd4) state_next = S_PREP;
            end
            S_PREP: begin
                state_next = S_CALC;
                start_next = 1'b1;
            end
            S_CALC: begin
                if (px_res.done) begin
                    if (step_reg == 2'd2) begin
                        state_next = S_DONE;
                    end else begin
                        start_next = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            cnt_reg      <= '0;
            epx_reg      <= '0;
            epy_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            if (cfg_we) cnt_reg <= cfg_wdata;
            if (accept && (s_cmd == pcse_pkg::CMD_WR_EPX)) epx_reg <= s_val;
            if (accept && (s_cmd == pcse_pkg::CMD_WR_EPY)) epy_reg <= s_val;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept && (s_cmd == pcse_pkg::CMD_EVAL)) begin
                    u_reg    <= s_u;
                    i_reg    <= '0;
                    zero_reg <= few_points;
                    sat_reg  <= 1'b0;
                    k_reg    <= '0;
                    step_reg <= '0;
                end
            end
            S_SEARCH: begin
                if (!search_done) begin
                    i_reg <= i_reg + CW'(1);
                end else begin
                    seg_reg    <= hit ? i_reg : cnt_last;
                    beyond_reg <= !hit;
                end
            end
            S_FETCH: begin
                // data for slot k-1 lands in the cycle after its address
                k_reg <= k_reg + 3'd1;
                if (k_reg != 3'd0) begin
                    cx_reg[2'(k_reg - 3'd1)] <= cf_rdata[DW-1:0];
                    cy_reg[2'(k_reg - 3'd1)] <= cf_rdata[2*DW-1:DW];
                end
            end
            S_PREP: begin
                t3x_reg <= t3x.value;
                t2x_reg <= t2x.value;
                t3y_reg <= t3y.value;
                t2y_reg <= t2y.value;
                sat_reg <= sat_reg | t3x.clipped | t2x.clipped
                         | t3y.clipped | t2y.clipped;
            end
            S_CALC: begin
                if (px_res.done) begin
                    accpx_reg <= px_res.value;
                    accpy_reg <= py_res.value;
                    if (step_reg != 2'd2) begin
                        accsx_reg <= sx_res.value;
                        accsy_reg <= sy_res.value;
                    end
                    // point clipping only counts when the cubic is used
                    sat_reg <= sat_reg
                             | (!beyond_reg && (px_res.sat || py_res.sat))
                             | ((step_reg != 2'd2) && (sx_res.sat || sy_res.sat));
                    step_reg <= step_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res_seg, res_sy, res_sx, res_py, res_px};
            m_tuser_reg <= {res_sat, res_beyond};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* src/pcse_checker.sv */
// Port-level checker for the spline evaluator, bound to the top level.
// Depends on pcse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcse_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [pcse_pkg::CMD_W-1:0]        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pcse_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [pcse_pkg::M_TUSER_W-1:0]    m_tuser
);

    // reset empties the output register
    `ASSERT_CLK(a_rst_no_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a stalled result holds
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // table loads complete in the cycle they are taken
    `ASSERT_CLKD(a_load_ready, aclk, aresetn, s_tvalid && s_tready && (s_tuser != pcse_pkg::CMD_EVAL) |=> s_tready, "not ready after load")

    // an evaluate occupies the sequencer for at least the next cycle
    `ASSERT_CLKD(a_eval_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == pcse_pkg::CMD_EVAL) |=> !s_tready, "ready right after evaluate")

endmodule

bind piecewise_cubic_spline_evaluator pcse_checker u_pcse_checker (.*);
